@@ src/isw_pkg.sv @@
`default_nettype none

package isw_pkg;

  // Graph size and derived widths
  localparam int MaxNodes = 5;
  localparam int AdjW     = MaxNodes * MaxNodes;
  localparam int NodeW    = 3;
  localparam int LenW     = 3;
  localparam int NCntW    = $clog2(MaxNodes + 1);
  localparam int CountW   = 10;

  // Configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = AdjW;

  // Command queue between front and back
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  typedef logic [NodeW-1:0]    node_t;
  typedef logic [LenW-1:0]     len_t;
  typedef logic [NCntW-1:0]    ncnt_t;
  typedef logic [CountW-1:0]   count_t;
  typedef logic [CountW:0]     count_sum_t;
  typedef logic [MaxNodes-1:0] vmask_t;
  typedef logic [AdjW-1:0]     adj_t;
  typedef logic [FifoPtrW-1:0] fifo_ptr_t;
  typedef logic [FifoCntW-1:0] fifo_cnt_t;

  localparam count_t CountMax      = {CountW{1'b1}};
  localparam node_t  NodeCountRst  = node_t'(5);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgAdjacency = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgNodeCount = 1'b1;

  // Input transaction payload
  typedef struct packed {
    vmask_t subset_mask;
    node_t  start_node;
    node_t  end_node;
    len_t   walk_length;
  } in_t;

  // Output transaction payload
  typedef struct packed {
    count_t walk_count;
    logic   length_error;
  } out_t;

  // Classified command handed from front to back
  typedef struct packed {
    vmask_t mask;       // subset restricted to vertices in use
    vmask_t init_vec;   // one-hot start, empty if start is absent
    vmask_t end_sel;    // one-hot end, empty if end is absent
    len_t   steps;      // walk length, zero on error
    logic   len_err;
  } cmd_t;

  // Handshake between queue and back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_out_t;

endpackage

`default_nettype wire

@@ src/induced_subgraph_walk_counter.sv @@
// Flow: an input transaction is classified and registered in the command queue;
// the back end loads it when idle, runs L walk steps (L = walk_length, zero for
// a length error) and registers the result once the output register is free.
// The back end's vector update does one walk step per cycle and takes a new item
// only when done with the last; the queue holds two classified items.
// Reset: adjacency clears to no edges, node count to 5, queue and output empty.
`default_nettype none

module induced_subgraph_walk_counter (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire isw_pkg::in_t                 in_data_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output isw_pkg::out_t                     out_data_o,
  input  wire                               cfg_we_i,
  input  wire [isw_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire [isw_pkg::CfgDataW-1:0]       cfg_data_i
);

  isw_pkg::adj_t   adj_q;
  isw_pkg::node_t  node_count_q;
  isw_pkg::cmd_t   cmd;
  isw_pkg::q_out_t q_out;
  logic            q_full;
  logic            pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q        <= '0;
      node_count_q <= isw_pkg::NodeCountRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        isw_pkg::CfgAdjacency: adj_q <= isw_pkg::adj_t'(cfg_data_i);
        isw_pkg::CfgNodeCount: node_count_q <= isw_pkg::node_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign in_ready_o = !q_full;

  isw_front u_front (
    .in_data_i    (in_data_i),
    .node_count_i (node_count_q),
    .cmd_o        (cmd)
  );

  isw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && !q_full),
    .push_data_i (cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .q_o         (q_out)
  );

  isw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adj_i       (adj_q),
    .q_i         (q_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ src/isw_front.sv @@
`default_nettype none

module isw_front (
  input  wire isw_pkg::in_t   in_data_i,
  input  wire isw_pkg::node_t node_count_i,
  output isw_pkg::cmd_t       cmd_o
);

  isw_pkg::ncnt_t n_eff;
  isw_pkg::ncnt_t len_ext;
  isw_pkg::vmask_t mask;
  isw_pkg::vmask_t init_vec;
  isw_pkg::vmask_t end_sel;
  logic len_err;

  // Effective node count saturates at the graph size
  always_comb begin
    if (isw_pkg::ncnt_t'(node_count_i) > isw_pkg::ncnt_t'(isw_pkg::MaxNodes) ||
        (isw_pkg::NodeW > isw_pkg::NCntW &&
         node_count_i > isw_pkg::node_t'(isw_pkg::MaxNodes))) begin
      n_eff = isw_pkg::ncnt_t'(isw_pkg::MaxNodes);
    end else begin
      n_eff = isw_pkg::ncnt_t'(node_count_i);
    end
  end

  assign len_ext = isw_pkg::ncnt_t'(in_data_i.walk_length);
  assign len_err = (len_ext >= n_eff) ||
                   (isw_pkg::LenW > isw_pkg::NCntW &&
                    in_data_i.walk_length > isw_pkg::len_t'(isw_pkg::MaxNodes));

  // Vertex classification: in use, in subset, endpoints
  always_comb begin
    for (int v = 0; v < isw_pkg::MaxNodes; v++) begin
      mask[v]     = in_data_i.subset_mask[v] && (isw_pkg::ncnt_t'(v) < n_eff);
      init_vec[v] = mask[v] && (in_data_i.start_node == isw_pkg::node_t'(v));
      end_sel[v]  = mask[v] && (in_data_i.end_node == isw_pkg::node_t'(v));
    end
  end

  always_comb begin
    cmd_o.mask     = mask;
    cmd_o.init_vec = init_vec;
    cmd_o.end_sel  = end_sel;
    cmd_o.steps    = len_err ? '0 : in_data_i.walk_length;
    cmd_o.len_err  = len_err;
  end

endmodule

`default_nettype wire

@@ src/isw_fifo.sv @@
`default_nettype none

module isw_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  wire isw_pkg::cmd_t  push_data_i,
  output logic                full_o,
  input  wire                 pop_i,
  output isw_pkg::q_out_t     q_o
);

  isw_pkg::cmd_t     mem_q [isw_pkg::FifoDepth];
  isw_pkg::fifo_ptr_t wptr_q, wptr_d;
  isw_pkg::fifo_ptr_t rptr_q, rptr_d;
  isw_pkg::fifo_cnt_t cnt_q, cnt_d;

  function automatic isw_pkg::fifo_ptr_t ptr_inc(isw_pkg::fifo_ptr_t p);
    if (p == isw_pkg::fifo_ptr_t'(isw_pkg::FifoDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full_o    = (cnt_q == isw_pkg::fifo_cnt_t'(isw_pkg::FifoDepth));
  assign q_o.valid = (cnt_q != '0);
  assign q_o.cmd   = mem_q[rptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wptr_d = push_i ? ptr_inc(wptr_q) : wptr_q;
    rptr_d = pop_i ? ptr_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q + isw_pkg::fifo_cnt_t'(push_i) - isw_pkg::fifo_cnt_t'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> q_o.valid)
    else $error("command queue read while empty");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= isw_pkg::fifo_cnt_t'(isw_pkg::FifoDepth))
    else $error("command queue fill count out of range");

endmodule

`default_nettype wire

@@ src/isw_back.sv @@
`default_nettype none

module isw_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire isw_pkg::adj_t  adj_i,
  input  wire isw_pkg::q_out_t q_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output isw_pkg::out_t       out_data_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q, state_d;
  isw_pkg::count_t vec_q [isw_pkg::MaxNodes];
  isw_pkg::count_t vec_d [isw_pkg::MaxNodes];
  isw_pkg::count_t nxt   [isw_pkg::MaxNodes];
  isw_pkg::vmask_t mask_q, mask_d;
  isw_pkg::vmask_t end_q, end_d;
  isw_pkg::len_t   steps_q, steps_d;
  logic            err_q, err_d;
  logic            out_valid_q, out_valid_d;
  isw_pkg::out_t   out_data_q, out_data_d;
  isw_pkg::count_t pick;
  logic            out_free;

  // One walk step: every in-subset node sums its in-subset predecessors
  always_comb begin
    isw_pkg::count_sum_t acc;
    for (int j = 0; j < isw_pkg::MaxNodes; j++) begin
      acc = '0;
      for (int v = 0; v < isw_pkg::MaxNodes; v++) begin
        if (mask_q[v] && adj_i[v * isw_pkg::MaxNodes + j]) begin
          acc = acc + isw_pkg::count_sum_t'(vec_q[v]);
          if (acc > isw_pkg::count_sum_t'(isw_pkg::CountMax)) begin
            acc = isw_pkg::count_sum_t'(isw_pkg::CountMax);
          end
        end
      end
      nxt[j] = mask_q[j] ? isw_pkg::count_t'(acc) : '0;
    end
  end

  // Entry at the end node
  always_comb begin
    pick = '0;
    for (int j = 0; j < isw_pkg::MaxNodes; j++) begin
      if (end_q[j]) begin
        pick = pick | vec_q[j];
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == ST_IDLE) && q_i.valid;

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    vec_d       = vec_q;
    mask_d      = mask_q;
    end_d       = end_q;
    steps_d     = steps_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_i.valid) begin
          for (int j = 0; j < isw_pkg::MaxNodes; j++) begin
            vec_d[j] = isw_pkg::count_t'(q_i.cmd.init_vec[j]);
          end
          mask_d  = q_i.cmd.mask;
          end_d   = q_i.cmd.end_sel;
          steps_d = q_i.cmd.steps;
          err_d   = q_i.cmd.len_err;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (steps_q != '0) begin
          vec_d   = nxt;
          steps_d = steps_q - 1'b1;
        end else if (out_free) begin
          out_valid_d             = 1'b1;
          out_data_d.walk_count   = err_q ? '0 : pick;
          out_data_d.length_error = err_q;
          state_d                 = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      steps_q     <= '0;
      err_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      steps_q     <= steps_d;
      err_q       <= err_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    vec_q      <= vec_d;
    mask_q     <= mask_d;
    end_q      <= end_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.length_error |-> out_data_q.walk_count == '0)
    else $error("length error reported with nonzero count");

  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q < isw_pkg::len_t'(isw_pkg::MaxNodes))
    else $error("step counter exceeds longest legal walk");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == ST_RUN)
    else $error("command taken without starting a walk");

endmodule

`default_nettype wire
